### rtl/loki97_block_cipher_macros.svh
// assertion macros for the loki97 block cipher rtl
// no dependencies; expects clk and rst_n in the including scope
`ifndef LOKI97_BLOCK_CIPHER_MACROS_SVH
`define LOKI97_BLOCK_CIPHER_MACROS_SVH
`ifndef SYNTHESIS
`define LOKI_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("loki97 assertion failed");
`define LOKI_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("loki97 assertion failed");
`else
`define LOKI_ASSERT_IMP(lbl, a, b)
`define LOKI_ASSERT_NXT(lbl, a, b)
`endif
`endif

### rtl/loki_pkg.sv
// loki97 package: sizes, register codes, s-box and f function
// no dependencies
package loki_pkg;

    localparam int ROUND_COUNT = 16;
    localparam int KEY_COUNT   = 3 * ROUND_COUNT;
    localparam int KEY_AW      = $clog2(KEY_COUNT);

    localparam logic [63:0] DELTA   = 64'h9E3779B97F4A7C15;
    localparam logic [13:0] S1_POLY = 14'h2911;
    localparam logic [11:0] S2_POLY = 12'h0AA7;
    localparam logic [12:0] S1_MASK = 13'h1FFF;
    localparam logic [10:0] S2_MASK = 11'h7FF;

    typedef enum logic [2:0] {
        REG_KEY_A,
        REG_KEY_B,
        REG_KEY_C,
        REG_KEY_D,
        REG_KEY_SIZE,
        REG_CHAIN_MODE,
        REG_IV_LEFT,
        REG_IV_RIGHT
    } cfg_reg_t;

    // x^k mod poly, only ever called with constant k
    function automatic logic [12:0] red13(input int k);
        logic [13:0] p;
        p = 14'h1;
        for (int i = 0; i < k; i++)
        begin
            p = p << 1;
            if (p[13])
                p = p ^ S1_POLY;
        end
        return p[12:0];
    endfunction

    function automatic logic [10:0] red11(input int k);
        logic [11:0] p;
        p = 12'h1;
        for (int i = 0; i < k; i++)
        begin
            p = p << 1;
            if (p[11])
                p = p ^ S2_POLY;
        end
        return p[10:0];
    endfunction

    // carry-less product, then fold the high bits with constant residues
    function automatic logic [12:0] gf13_mul(input logic [12:0] a, input logic [12:0] b);
        logic [24:0] prod;
        logic [12:0] res;
        prod = '0;
        for (int i = 0; i < 13; i++)
        begin
            if (b[i])
                prod = prod ^ ({12'b0, a} << i);
        end
        res = prod[12:0];
        for (int k = 13; k < 25; k++)
        begin
            if (prod[k])
                res = res ^ red13(k);
        end
        return res;
    endfunction

    function automatic logic [10:0] gf11_mul(input logic [10:0] a, input logic [10:0] b);
        logic [20:0] prod;
        logic [10:0] res;
        prod = '0;
        for (int i = 0; i < 11; i++)
        begin
            if (b[i])
                prod = prod ^ ({10'b0, a} << i);
        end
        res = prod[10:0];
        for (int k = 11; k < 21; k++)
        begin
            if (prod[k])
                res = res ^ red11(k);
        end
        return res;
    endfunction

    function automatic logic [7:0] sbox1(input logic [12:0] idx);
        logic [12:0] x;
        logic [12:0] sq;
        logic [12:0] cu;
        x  = idx ^ S1_MASK;
        sq = gf13_mul(x, x);
        cu = gf13_mul(x, sq);
        return cu[7:0];
    endfunction

    function automatic logic [7:0] sbox2(input logic [10:0] idx);
        logic [10:0] x;
        logic [10:0] sq;
        logic [10:0] cu;
        x  = idx ^ S2_MASK;
        sq = gf11_mul(x, x);
        cu = gf11_mul(x, sq);
        return cu[7:0];
    endfunction

    function automatic logic [63:0] f_fn(input logic [63:0] a, input logic [63:0] b);
        logic [31:0] dl;
        logic [31:0] dr;
        logic [31:0] bl;
        logic [7:0]  s [8];
        logic [63:0] e;
        logic [31:0] el;
        logic [31:0] er;
        logic [31:0] fl;
        logic [31:0] fr;
        bl = b[63:32];
        dl = (a[63:32] & ~b[31:0]) | (a[31:0] & b[31:0]);
        dr = (a[31:0] & ~b[31:0]) | (a[63:32] & b[31:0]);
        s[7] = sbox1({dr[4:0], dl[31:24]});
        s[6] = sbox2(dl[26:16]);
        s[5] = sbox1(dl[20:8]);
        s[4] = sbox2(dl[10:0]);
        s[3] = sbox2({dl[2:0], dr[31:24]});
        s[2] = sbox1(dr[28:16]);
        s[1] = sbox2(dr[18:8]);
        s[0] = sbox1(dr[12:0]);
        e = '0;
        // bit j of s-box k lands on bit 8j+7-k
        for (int k = 0; k < 8; k++)
        begin
            for (int j = 0; j < 8; j++)
            begin
                e[8 * j + 7 - k] = s[k][j];
            end
        end
        el = e[63:32];
        er = e[31:0];
        fl = {sbox2({bl[31:29], el[31:24]}), sbox2({bl[28:26], el[23:16]}),
              sbox1({bl[25:21], el[15:8]}), sbox1({bl[20:16], el[7:0]})};
        fr = {sbox2({bl[15:13], er[31:24]}), sbox2({bl[12:10], er[23:16]}),
              sbox1({bl[9:5], er[15:8]}), sbox1({bl[4:0], er[7:0]})};
        return {fl, fr};
    endfunction

endpackage

### rtl/loki97_block_cipher.sv
// loki97 block cipher: an accepted item is loaded, runs 16 rounds of three steps each
// and then passes an output step; no new item is taken until the last one has left the
// output step. a stalled result holds the next item in its output step.
// after reset and after any key or key_size write the schedule runs (load, init steps for
// short keys, a sum and a generate step per round key) and no item is taken meanwhile;
// reset is async active low. uses loki_pkg and loki97_block_cipher_macros.svh
`include "loki97_block_cipher_macros.svh"

module loki97_block_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [63:0] block_left,
    input  logic [63:0] block_right,
    input  logic        last_block,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] out_left,
    output logic [63:0] out_right
);

    typedef enum logic [2:0] {
        S_KLOAD,
        S_INIT1,
        S_INIT2,
        S_KSUM,
        S_KGEN,
        S_IDLE,
        S_ROUND,
        S_DONE
    } state_t;

    localparam int AW = loki_pkg::KEY_AW;

    state_t      state_reg;
    logic [63:0] key_a_reg, key_b_reg, key_c_reg, key_d_reg;
    logic [1:0]  key_size_reg;
    logic        chain_mode_reg;
    logic [63:0] iv_l_reg, iv_r_reg;
    logic [63:0] k4_reg, k3_reg, k2_reg, k1_reg, delta_reg;
    logic [63:0] acc_reg, fo_reg, l_reg, r_reg;
    logic [63:0] mask_l_reg, mask_r_reg;
    logic [63:0] chain_hi_reg, chain_lo_reg;
    logic        fresh_reg, decrypt_reg, enc_chain_reg;
    logic [AW-1:0] kc_reg;
    logic [1:0]  sub_reg;
    logic        out_valid_reg;
    logic [63:0] out_left_reg, out_right_reg;

    logic [63:0] round_keys [loki_pkg::KEY_COUNT];
    logic [63:0] rdata_reg;
    logic [AW-1:0] raddr;

    logic [63:0] f_a, f_b, f_out, arith_src, arith, ph_l, ph_r;
    logic        key_last, key_we, key_wr;

    assign key_last = kc_reg == AW'(loki_pkg::KEY_COUNT - 1);
    assign key_we   = state_reg == S_KGEN;
    assign key_wr   = cfg_write && (cfg_index == loki_pkg::REG_KEY_A
                   || cfg_index == loki_pkg::REG_KEY_B || cfg_index == loki_pkg::REG_KEY_C
                   || cfg_index == loki_pkg::REG_KEY_D || cfg_index == loki_pkg::REG_KEY_SIZE);

    // the shared f unit
    always_comb
    begin
        unique case (state_reg)
            S_INIT1:
            begin
                f_a = k3_reg;
                f_b = k4_reg;
            end
            S_INIT2:
            begin
                f_a = k4_reg;
                f_b = k3_reg;
            end
            S_KGEN:
            begin
                f_a = acc_reg;
                f_b = k2_reg;
            end
            default:
            begin
                f_a = acc_reg;
                f_b = rdata_reg;
            end
        endcase
    end

    assign f_out = loki_pkg::f_fn(f_a, f_b);

    assign arith_src = (sub_reg == 2'd0) ? r_reg : acc_reg;
    assign arith     = decrypt_reg ? (arith_src - rdata_reg) : (arith_src + rdata_reg);

    assign ph_l = fresh_reg ? iv_l_reg : chain_hi_reg;
    assign ph_r = fresh_reg ? iv_r_reg : chain_lo_reg;

    // key address runs one step ahead of the round datapath
    always_comb
    begin
        if (state_reg == S_IDLE)
            raddr = opcode ? AW'(loki_pkg::KEY_COUNT - 1) : '0;
        else if (key_last)
            raddr = '0;
        else if (decrypt_reg)
            raddr = AW'(loki_pkg::KEY_COUNT - 2) - kc_reg;
        else
            raddr = kc_reg + AW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
            round_keys[kc_reg] <= k4_reg ^ f_out;
        rdata_reg <= round_keys[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_KLOAD;
            key_a_reg      <= '0;
            key_b_reg      <= '0;
            key_c_reg      <= '0;
            key_d_reg      <= '0;
            key_size_reg   <= '0;
            chain_mode_reg <= 1'b0;
            iv_l_reg       <= '0;
            iv_r_reg       <= '0;
            chain_hi_reg   <= '0;
            chain_lo_reg   <= '0;
            fresh_reg      <= 1'b1;
            decrypt_reg    <= 1'b0;
            enc_chain_reg  <= 1'b0;
            kc_reg         <= '0;
            sub_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_KLOAD:
                begin
                    k4_reg    <= key_a_reg;
                    k3_reg    <= key_b_reg;
                    k2_reg    <= key_c_reg;
                    k1_reg    <= key_d_reg;
                    delta_reg <= loki_pkg::DELTA;
                    kc_reg    <= '0;
                    // reserved size code runs as a 256-bit key
                    priority if (key_size_reg == 2'd0)
                        state_reg <= S_INIT1;
                    else if (key_size_reg == 2'd1)
                        state_reg <= S_INIT2;
                    else
                        state_reg <= S_KSUM;
                end
                S_INIT1:
                begin
                    k2_reg    <= f_out;
                    state_reg <= S_INIT2;
                end
                S_INIT2:
                begin
                    k1_reg    <= f_out;
                    state_reg <= S_KSUM;
                end
                S_KSUM:
                begin
                    acc_reg   <= k1_reg + k3_reg + delta_reg;
                    state_reg <= S_KGEN;
                end
                S_KGEN:
                begin
                    k4_reg    <= k3_reg;
                    k3_reg    <= k2_reg;
                    k2_reg    <= k1_reg;
                    k1_reg    <= k4_reg ^ f_out;
                    delta_reg <= delta_reg + loki_pkg::DELTA;
                    if (key_last)
                    begin
                        kc_reg    <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        kc_reg    <= kc_reg + AW'(1);
                        state_reg <= S_KSUM;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        decrypt_reg <= opcode;
                        kc_reg      <= '0;
                        sub_reg     <= '0;
                        state_reg   <= S_ROUND;
                        if (chain_mode_reg && !opcode)
                        begin
                            l_reg         <= block_left ^ ph_l;
                            r_reg         <= block_right ^ ph_r;
                            mask_l_reg    <= '0;
                            mask_r_reg    <= '0;
                            enc_chain_reg <= 1'b1;
                        end
                        else if (chain_mode_reg)
                        begin
                            l_reg         <= block_left;
                            r_reg         <= block_right;
                            mask_l_reg    <= ph_l;
                            mask_r_reg    <= ph_r;
                            chain_hi_reg  <= block_left;
                            chain_lo_reg  <= block_right;
                            enc_chain_reg <= 1'b0;
                        end
                        else
                        begin
                            l_reg         <= block_left;
                            r_reg         <= block_right;
                            mask_l_reg    <= '0;
                            mask_r_reg    <= '0;
                            enc_chain_reg <= 1'b0;
                        end
                        fresh_reg <= chain_mode_reg ? last_block : 1'b1;
                    end
                end
                S_ROUND:
                begin
                    kc_reg <= key_last ? '0 : kc_reg + AW'(1);
                    unique case (sub_reg)
                        2'd0:
                        begin
                            acc_reg <= arith;
                            sub_reg <= 2'd1;
                        end
                        2'd1:
                        begin
                            fo_reg  <= f_out;
                            sub_reg <= 2'd2;
                        end
                        default:
                        begin
                            l_reg   <= arith;
                            r_reg   <= l_reg ^ fo_reg;
                            sub_reg <= 2'd0;
                            if (key_last)
                                state_reg <= S_DONE;
                        end
                    endcase
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_left_reg  <= r_reg ^ mask_l_reg;
                        out_right_reg <= l_reg ^ mask_r_reg;
                        out_valid_reg <= 1'b1;
                        if (enc_chain_reg)
                        begin
                            chain_hi_reg <= r_reg;
                            chain_lo_reg <= l_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
            endcase

            if (cfg_write)
            begin
                unique case (loki_pkg::cfg_reg_t'(cfg_index))
                    loki_pkg::REG_KEY_A:      key_a_reg <= cfg_data;
                    loki_pkg::REG_KEY_B:      key_b_reg <= cfg_data;
                    loki_pkg::REG_KEY_C:      key_c_reg <= cfg_data;
                    loki_pkg::REG_KEY_D:      key_d_reg <= cfg_data;
                    loki_pkg::REG_KEY_SIZE:   key_size_reg <= cfg_data[1:0];
                    loki_pkg::REG_CHAIN_MODE:
                    begin
                        chain_mode_reg <= cfg_data[0];
                        fresh_reg      <= 1'b1;
                    end
                    loki_pkg::REG_IV_LEFT:
                    begin
                        iv_l_reg  <= cfg_data;
                        fresh_reg <= 1'b1;
                    end
                    loki_pkg::REG_IV_RIGHT:
                    begin
                        iv_r_reg  <= cfg_data;
                        fresh_reg <= 1'b1;
                    end
                endcase
                // any key change restarts the schedule
                if (key_wr)
                    state_reg <= S_KLOAD;
            end
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;

    `LOKI_ASSERT_NXT(a_key_restart, key_wr, state_reg == S_KLOAD)
    `LOKI_ASSERT_NXT(a_last_round_done, state_reg == S_ROUND && sub_reg == 2'd2 && key_last
        && !key_wr, state_reg == S_DONE)
    `LOKI_ASSERT_IMP(a_sub_range, state_reg == S_ROUND, sub_reg != 2'd3)
    `LOKI_ASSERT_NXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(out_left) && $stable(out_right))

endmodule
